/* src/pixel_run_write_combiner_macros.svh */
// assertion macros shared by the pixel run write combiner checkers
// no dependencies; included by the checker file
`ifndef PIXEL_RUN_WRITE_COMBINER_MACROS_SVH
`define PIXEL_RUN_WRITE_COMBINER_MACROS_SVH

// checked only outside reset
`define PRWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PRWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/prwc_pkg.sv */
// package for the pixel run write combiner: sizes, state codes, result item
// and the rgb565 packing function; no dependencies
package prwc_pkg;

  localparam int LINE_WIDTH = 32;
  localparam int COL_BITS   = $clog2(LINE_WIDTH);
  localparam int ROW_BITS   = 12;
  localparam int PIX_BITS   = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_READ,
    ST_WRAP
  } state_t;

  typedef struct packed {
    logic                is_header;
    logic [COL_BITS-1:0] start_col;
    logic [COL_BITS-1:0] end_col;
    logic [ROW_BITS-1:0] out_row;
    logic [PIX_BITS-1:0] pixel;
    logic                last;
  } out_item_t;

  // status of the output buffer seen by the sequencer
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } obuf_stat_t;

  function automatic logic [PIX_BITS-1:0] rgb565(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* src/prwc_if.sv */
// channel interfaces of the pixel run write combiner: input write beats and
// result beats, each with valid/ready; depends on prwc_pkg
interface prwc_in_if import prwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [COL_BITS-1:0] x;
  logic [ROW_BITS-1:0] y;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;

  modport source (output valid, cmd, x, y, red, green, blue, input ready);
  modport sink (input valid, cmd, x, y, red, green, blue, output ready);
endinterface

interface prwc_out_if import prwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_header;
  logic [COL_BITS-1:0] start_col;
  logic [COL_BITS-1:0] end_col;
  logic [ROW_BITS-1:0] out_row;
  logic [PIX_BITS-1:0] pixel;
  logic                last;

  modport source (output valid, is_header, start_col, end_col, out_row, pixel, last,
                  input ready);
  modport sink (input valid, is_header, start_col, end_col, out_row, pixel, last,
                output ready);
endinterface

/* src/prwc_obuf.sv */
// two-entry output buffer that drives the result channel
// depends on prwc_pkg and prwc_out_if
module prwc_obuf import prwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  out_item_t         push_item,
  output obuf_stat_t        stat,
  prwc_out_if.source        out_ch
);

  out_item_t  buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;
  out_item_t  head;

  assign head = buf_r[rd_ptr_r];
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.is_header = head.is_header;
  assign out_ch.start_col = head.start_col;
  assign out_ch.end_col   = head.end_col;
  assign out_ch.out_row   = head.out_row;
  assign out_ch.pixel     = head.pixel;
  assign out_ch.last      = head.last;

  assign stat.count = cnt_r;
  assign stat.pop   = pop;

endmodule

/* src/pixel_run_write_combiner.sv */
// pixel run write combiner: a beat that ends a run gives its header beat on out_ch
// via ST_HDR, the staged beat and the output buffer, then one pixel beat per cycle
// while out_ch takes them; a write that extends the open run is taken every cycle;
// a beat that ends a run holds in_ch.ready low through ST_HDR, ST_READ (the single
// read port of the line store reads one column per cycle) and ST_WRAP, longer if out_ch stalls
// reset (rst_n low, synchronous): no run open, output buffer empty, line store kept
module pixel_run_write_combiner import prwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  prwc_in_if.sink    in_ch,
  prwc_out_if.source out_ch
);

  // sequencer state
  state_t              state_r;
  state_t              state_nxt;

  // open run
  logic                run_open_r;
  logic [COL_BITS-1:0] run_first_r;
  logic [COL_BITS-1:0] run_final_r;
  logic [ROW_BITS-1:0] run_row_r;

  // write that ended a run, held until the run has been read out
  logic                pend_r;
  logic [COL_BITS-1:0] pend_x_r;
  logic [ROW_BITS-1:0] pend_y_r;
  logic [PIX_BITS-1:0] pend_pix_r;

  // readout column and the stage that covers the memory read latency
  logic [COL_BITS-1:0] col_r;
  logic                st_vld_r;
  logic                st_hdr_r;
  logic                st_last_r;

  // line store, one entry per column
  logic [PIX_BITS-1:0] line_mem [LINE_WIDTH];
  logic [PIX_BITS-1:0] rdata_r;

  logic                accept;
  logic                brk;
  logic [PIX_BITS-1:0] in_pix;
  logic [2:0]          occ;
  logic                space_ok;
  logic                issue_hdr;
  logic                issue_rd;
  logic                mem_we;
  logic [COL_BITS-1:0] mem_waddr;
  logic [PIX_BITS-1:0] mem_wdata;
  out_item_t           push_item;
  obuf_stat_t          obuf_stat;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_pix = rgb565(in_ch.red, in_ch.green, in_ch.blue);

  // a write ends the open run on another row, left of the start, or past end + 1
  assign brk = (in_ch.y != run_row_r) || (in_ch.x < run_first_r) ||
               ({1'b0, in_ch.x} > ({1'b0, run_final_r} + 1'b1));

  // buffer entries in use once this cycle's pop and the staged beat are counted
  assign occ      = {1'b0, obuf_stat.count} + {2'b00, st_vld_r} - {2'b00, obuf_stat.pop};
  assign space_ok = (occ < 3'd2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && run_open_r && (in_ch.cmd || brk)) begin
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        if (space_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (space_ok && (col_r == run_final_r)) begin
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    issue_hdr   = 1'b0;
    issue_rd    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = in_ch.x;
    mem_wdata   = in_pix;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        // a write that stays in the run (or opens one) goes straight to the store
        mem_we = accept && !in_ch.cmd && !(run_open_r && brk);
      end
      ST_HDR: begin
        issue_hdr = space_ok;
      end
      ST_READ: begin
        issue_rd = space_ok;
      end
      ST_WRAP: begin
        mem_we    = pend_r;
        mem_waddr = pend_x_r;
        mem_wdata = pend_pix_r;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      run_open_r <= 1'b0;
      pend_r     <= 1'b0;
      st_vld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      st_vld_r <= issue_hdr || issue_rd;
      if (state_r == ST_IDLE && accept) begin
        if (in_ch.cmd) begin
          pend_r <= 1'b0;
        end else if (run_open_r && brk) begin
          pend_r <= 1'b1;
        end else begin
          run_open_r <= 1'b1;
        end
      end else if (state_r == ST_WRAP) begin
        // the held write opens the fresh run, a flush leaves none open
        run_open_r <= pend_r;
        pend_r     <= 1'b0;
      end
    end
  end

  // run bounds, held write and readout column (payload, no reset)
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && !in_ch.cmd) begin
      if (!run_open_r) begin
        run_first_r <= in_ch.x;
        run_final_r <= in_ch.x;
        run_row_r   <= in_ch.y;
      end else if (!brk && (in_ch.x > run_final_r)) begin
        run_final_r <= in_ch.x;
      end
      pend_x_r   <= in_ch.x;
      pend_y_r   <= in_ch.y;
      pend_pix_r <= in_pix;
    end else if (state_r == ST_WRAP && pend_r) begin
      run_first_r <= pend_x_r;
      run_final_r <= pend_x_r;
      run_row_r   <= pend_y_r;
    end
    if (issue_hdr) begin
      col_r <= run_first_r;
    end else if (issue_rd) begin
      col_r <= col_r + 1'b1;
    end
    if (issue_hdr || issue_rd) begin
      st_hdr_r  <= issue_hdr;
      st_last_r <= issue_rd && (col_r == run_final_r);
    end
  end

  // line store: one write and one read per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (issue_rd) begin
      rdata_r <= line_mem[col_r];
    end
  end

  // staged beat: header from the run bounds, pixel from the store
  always_comb begin
    push_item = '0;
    if (st_hdr_r) begin
      push_item.is_header = 1'b1;
      push_item.start_col = run_first_r;
      push_item.end_col   = run_final_r;
      push_item.out_row   = run_row_r;
    end else begin
      push_item.pixel = rdata_r;
      push_item.last  = st_last_r;
    end
  end

  prwc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (st_vld_r),
    .push_item (push_item),
    .stat      (obuf_stat),
    .out_ch    (out_ch)
  );

endmodule

/* src/prwc_checker.sv */
// port-level checks of the pixel run write combiner, bound to the top level
// depends on prwc_pkg and pixel_run_write_combiner_macros.svh
`include "pixel_run_write_combiner_macros.svh"

module prwc_checker import prwc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                is_header,
  input logic [COL_BITS-1:0] start_col,
  input logic [COL_BITS-1:0] end_col,
  input logic [ROW_BITS-1:0] out_row,
  input logic [PIX_BITS-1:0] pixel,
  input logic                last
);

  `PRWC_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_valid, "result beat right after reset")
  `PRWC_ASSERT(a_hdr_order, out_valid && is_header |-> start_col <= end_col && !last && pixel == '0, "bad header beat")
  `PRWC_ASSERT(a_pix_clean, out_valid && !is_header |-> start_col == '0 && end_col == '0 && out_row == '0, "pixel beat carries header fields")
  `PRWC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(is_header), "stalled result beat changed")

endmodule

bind pixel_run_write_combiner prwc_checker u_prwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .is_header (out_ch.is_header),
  .start_col (out_ch.start_col),
  .end_col   (out_ch.end_col),
  .out_row   (out_ch.out_row),
  .pixel     (out_ch.pixel),
  .last      (out_ch.last)
);

/* verif/prwc_tb_pkg.sv */
// command codes of the write channel shared by the combiner testbench files
// no dependencies; compiled before the checker and the testbench top
package prwc_tb_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

endpackage

/* verif/prwc_run_checker.sv */
// run checker for the pixel run write combiner: predicts header and pixel beats
// from accepted write beats and compares them with the result channel
// depends on prwc_pkg, prwc_tb_pkg and the channel interfaces in prwc_if
module prwc_run_checker import prwc_pkg::*; import prwc_tb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  prwc_in_if    in_mon,
  prwc_out_if   out_mon,
  output int    fail_count,
  output int    due_count
);

  logic                run_open;
  logic [COL_BITS-1:0] run_first;
  logic [COL_BITS-1:0] run_final;
  logic [ROW_BITS-1:0] run_row;
  logic [PIX_BITS-1:0] line_store [LINE_WIDTH];
  out_item_t           run_beats_due [$];
  int                  mismatches;

  assign fail_count = mismatches;

  initial begin
    mismatches = 0;
    due_count  = 0;
    run_open   = 1'b0;
    run_first  = '0;
    run_final  = '0;
    run_row    = '0;
    for (int c = 0; c < LINE_WIDTH; c++) line_store[c] = '0;
  end

  // header beat, then every column of the run in order
  task automatic close_run();
    out_item_t beat;
    int        c;
    if (!run_open) return;
    beat           = '0;
    beat.is_header = 1'b1;
    beat.start_col = run_first;
    beat.end_col   = run_final;
    beat.out_row   = run_row;
    run_beats_due.push_back(beat);
    for (c = int'(run_first); c <= int'(run_final); c++) begin
      beat       = '0;
      beat.pixel = line_store[c];
      beat.last  = (c == int'(run_final));
      run_beats_due.push_back(beat);
    end
    run_open = 1'b0;
  endtask

  task automatic take_write_beat();
    if (in_mon.cmd == CMD_FLUSH) begin
      close_run();
    end else begin
      // other row, left of start or a hole past the end closes the run
      if (run_open && (in_mon.y != run_row || in_mon.x < run_first ||
                       int'(in_mon.x) > int'(run_final) + 1))
        close_run();
      if (!run_open) begin
        run_open  = 1'b1;
        run_first = in_mon.x;
        run_final = in_mon.x;
        run_row   = in_mon.y;
      end
      if (in_mon.x > run_final) run_final = in_mon.x;
      line_store[in_mon.x] = {in_mon.red[7:3], in_mon.green[7:2], in_mon.blue[7:3]};
    end
  endtask

  task automatic note_mismatch(input string what, input out_item_t want,
                               input out_item_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $time, what);
      $display("  expected hdr=%0b start=%0d end=%0d row=%0d pix=%h last=%0b",
               want.is_header, want.start_col, want.end_col, want.out_row,
               want.pixel, want.last);
      $display("  actual   hdr=%0b start=%0d end=%0d row=%0d pix=%h last=%0b",
               seen.is_header, seen.start_col, seen.end_col, seen.out_row,
               seen.pixel, seen.last);
    end
  endtask

  task automatic check_result_beat();
    out_item_t seen;
    out_item_t want;
    seen.is_header = out_mon.is_header;
    seen.start_col = out_mon.start_col;
    seen.end_col   = out_mon.end_col;
    seen.out_row   = out_mon.out_row;
    seen.pixel     = out_mon.pixel;
    seen.last      = out_mon.last;
    if (run_beats_due.size() == 0) begin
      note_mismatch("result beat with nothing due", '0, seen);
    end else begin
      want = run_beats_due.pop_front();
      if (seen.is_header !== want.is_header || seen.start_col !== want.start_col ||
          seen.end_col !== want.end_col || seen.out_row !== want.out_row ||
          seen.pixel !== want.pixel || seen.last !== want.last)
        note_mismatch("wrong result beat", want, seen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      run_open  = 1'b0;
      run_first = '0;
      run_final = '0;
      run_row   = '0;
      run_beats_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) take_write_beat();
      if (out_mon.valid && out_mon.ready) check_result_beat();
    end
    due_count <= run_beats_due.size();
  end

endmodule

/* verif/tb_pixel_run_write_combiner.sv */
// testbench top for the pixel run write combiner: drives write and flush beats
// in bursts, stalls the result side, and gives the verdict from the run checker
// depends on prwc_pkg, prwc_tb_pkg, prwc_if, prwc_run_checker and the block
module tb_pixel_run_write_combiner import prwc_pkg::*; import prwc_tb_pkg::*; ();

  localparam int RANDOM_WRITES = 90;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 12;

  // receiver behaviors, switched at random whenever the low byte of rx_tick is zero
  typedef enum logic [1:0] {
    RX_FREE,
    RX_SPARSE,
    RX_RHYTHM,
    RX_COIN
  } rx_mode_t;

  logic     clk;
  logic     rst_n;
  int       fail_count;
  int       due_count;
  int       cycle_count;
  int       burst_left;
  rx_mode_t rx_mode;
  logic [15:0] rx_tick;

  prwc_in_if  in_ch ();
  prwc_out_if out_ch ();

  pixel_run_write_combiner u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  prwc_run_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always #5 clk = ~clk;

  // everything driven to a known value before the first edge
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_WRITE;
    in_ch.x      = '0;
    in_ch.y      = '0;
    in_ch.red    = '0;
    in_ch.green  = '0;
    in_ch.blue   = '0;
    out_ch.ready = 1'b0;
    rx_tick      = '0;
    rx_mode      = RX_FREE;
    cycle_count  = 0;
    burst_left   = 0;
  end

  // result side stall pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    if (rx_tick[7:0] == 8'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE: begin
        out_ch.ready <= 1'b1;
      end
      RX_SPARSE: begin
        // mostly stalled, a beat now and then
        out_ch.ready <= ($urandom_range(0, 3) == 0);
      end
      RX_RHYTHM: begin
        out_ch.ready <= (rx_tick[2:0] != 3'd5) && (rx_tick[2:0] != 3'd6);
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one write or flush beat; may open a gap between bursts, then holds the beat
  // until the block takes it
  task automatic offer_beat(input logic cmd, input logic [COL_BITS-1:0] x,
                            input logic [ROW_BITS-1:0] y, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no gap at all
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.x     <= x;
    in_ch.y     <= y;
    in_ch.red   <= r;
    in_ch.green <= g;
    in_ch.blue  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // flush with random don't-care fields
  task automatic offer_flush();
    offer_beat(CMD_FLUSH, COL_BITS'($urandom_range(0, 31)),
               ROW_BITS'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int   writes_sent;
    int   first_col;
    int   top_col;
    int   col;
    int   span;
    int   pick;
    logic sweep;
    logic [ROW_BITS-1:0] row;
    logic [ROW_BITS-1:0] prev_row;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: flush with nothing open is dropped
    offer_beat(CMD_FLUSH, 5'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    // run on row 0, with extremes of the color fields
    offer_beat(CMD_WRITE, 5'd0, 12'd0, 8'd0, 8'd0, 8'd0);
    offer_beat(CMD_WRITE, 5'd1, 12'd0, 8'd255, 8'd255, 8'd255);
    // overwrite inside the open run
    offer_beat(CMD_WRITE, 5'd1, 12'd0, 8'h80, 8'h40, 8'h08);
    // low color bits are dropped, pixel is zero
    offer_beat(CMD_WRITE, 5'd2, 12'd0, 8'd7, 8'd3, 8'd7);
    // hole past the run end closes the run
    offer_beat(CMD_WRITE, 5'd31, 12'd0, 8'hf8, 8'h00, 8'h00);
    // left of the run start closes the run
    offer_beat(CMD_WRITE, 5'd30, 12'd0, 8'h00, 8'hfc, 8'h00);
    // other row closes the run
    offer_beat(CMD_WRITE, 5'd30, 12'd4095, 8'h00, 8'h00, 8'hf8);
    offer_beat(CMD_WRITE, 5'd31, 12'd4095, 8'h55, 8'haa, 8'h55);
    offer_flush();
    offer_flush();
    // alternating row bits, single column runs, then a run of two columns
    offer_beat(CMD_WRITE, 5'd5, 12'haaa, 8'haa, 8'h55, 8'haa);
    offer_beat(CMD_WRITE, 5'd4, 12'haaa, 8'h55, 8'haa, 8'h55);
    offer_beat(CMD_WRITE, 5'd4, 12'h555, 8'h12, 8'h34, 8'h56);
    offer_beat(CMD_WRITE, 5'd5, 12'h555, 8'h9a, 8'hbc, 8'hde);
    offer_flush();

    // random: mostly runs of writes on one row, some noise beats
    writes_sent = 0;
    prev_row    = '0;
    while (writes_sent < RANDOM_WRITES) begin
      if ($urandom_range(0, 99) < 15) begin
        offer_beat($urandom_range(0, 1) ? CMD_FLUSH : CMD_WRITE,
                   COL_BITS'($urandom_range(0, 31)), ROW_BITS'($urandom_range(0, 4095)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        writes_sent++;
      end else begin
        // same row as before often, so left-of-start and merges happen
        row = ($urandom_range(0, 2) == 0) ? prev_row : ROW_BITS'($urandom_range(0, 4095));
        sweep = ($urandom_range(0, 9) == 0);
        if (sweep) begin
          // full line, the longest run there is
          first_col = 0;
          span      = LINE_WIDTH;
        end else begin
          first_col = $urandom_range(0, 31);
          span      = $urandom_range(1, 6);
        end
        col     = first_col;
        top_col = first_col;
        for (int k = 0; k < span; k++) begin
          offer_beat(CMD_WRITE, COL_BITS'(col), row, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          writes_sent++;
          pick = sweep ? 0 : $urandom_range(0, 9);
          if (pick < 7 && top_col < LINE_WIDTH - 1) begin
            top_col = top_col + 1;
            col     = top_col;
          end else if (pick < 9) begin
            col = $urandom_range(first_col, top_col);
          end
        end
        if ($urandom_range(0, 2) == 0) offer_flush();
        prev_row = row;
      end
    end
    // close whatever is still open
    offer_flush();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
